FILE: sv/tlfu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the text line firmware updater.
// No dependencies; the top level and the checker use this package.
package tlfu_pkg;

  localparam int LINE_CAPACITY_DEF = 579;
  localparam int IMAGE_BYTES_DEF   = 102400;

  localparam logic [31:0] APP_BASE_RST   = 32'h0800_7000;
  localparam logic [31:0] STACK_LOW_RST  = 32'h2000_0000;
  localparam logic [31:0] STACK_HIGH_RST = 32'h2000_5000;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_DATA  = 32'd1024;
  localparam logic [15:0] ERASED_HW = 16'hFFFF;
  localparam logic [7:0]  PAD_BYTE  = 8'hFF;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [39:0] KW_HELLO = 40'h48_45_4C_4C_4F;
  localparam logic [39:0] KW_ERASE = 40'h45_52_41_53_45;
  localparam logic [31:0] KW_CRC   = 32'h43_52_43_20;
  localparam logic [31:0] KW_BOOT  = 32'h42_4F_4F_54;

  typedef enum logic [3:0] {
    ST_BANNER   = 4'd0,
    ST_OK       = 4'd1,
    ST_FORMAT   = 4'd2,
    ST_LENGTH   = 4'd3,
    ST_RANGE    = 4'd4,
    ST_FLASH    = 4'd5,
    ST_MISMATCH = 4'd6,
    ST_NO_APP   = 4'd7,
    ST_UNKNOWN  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    CFG_APP_BASE   = 2'd0,
    CFG_STACK_LOW  = 2'd1,
    CFG_STACK_HIGH = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HDR, S_DECODE, S_ERASE, S_W_OFF, S_W_CHK, S_W_DAT,
    S_W_PRG, S_C_SIZE, S_C_EXP, S_C_RUN, S_B_RD, S_B_CHK, S_DONE
  } state_t;

  // Hex digit value; anything that is not a hex digit counts as zero.
  function automatic logic [3:0] nib(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    return v;
  endfunction

  // One byte of the reflected CRC-32, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/tlfu_if.sv
`timescale 1ns / 1ps
// Handshake channel interfaces of the updater: received bytes, results, configuration.
// Depends on nothing; the top level and its users connect through these.
interface tlfu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tlfu_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] crc_value;
  logic        start_app;
  modport source (output valid, output status, output crc_value, output start_app,
                  input ready);
  modport sink (input valid, input status, input crc_value, input start_app,
                output ready);
endinterface

interface tlfu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/text_line_firmware_updater.sv
`timescale 1ns / 1ps
// Top level of the text line firmware updater: command sequencer around two RAMs.
// Depends on tlfu_pkg, tlfu_if, tlfu_line_mem and tlfu_image_mem.
//
// Usage. Characters arrive as requests on rx; each ordinary character is taken and
// appended to the line store (characters past its capacity are
// dropped). A CR or LF on a non-empty line starts the command, and rx then holds
// ready low until the command's single result has been placed in the output register.
// Results leave as requests on res (status, crc_value, start_app); the output register
// lets the next line's characters be taken while a result still waits for the receiver.
// Only when a further command finishes while the earlier result is still unclaimed does
// the sequencer wait, and with it the rx channel.
// A line end passes through the header reads, a decode step and a result step, plus the
// command's own work: none for HELLO and unknown lines, a sweep over every halfword of
// the image for ERASE; the offset characters and space, a check, the data characters and
// the programmed halfwords for a W line; the characters after "CRC ", then the image bytes
// covered, for CRC; and the reads of the stack and start words for BOOT.
// These steps are set by the single read port of each RAM, which the sequencer steps through.
// Reset: after rst the image RAM is swept to erased, one halfword per cycle over all HW_COUNT
// halfwords (51200 at the default size) with rx held not ready; configuration writes on
// cfg are always taken and should only be made while the block is idle.
module text_line_firmware_updater #(
  parameter int LINE_CAPACITY = tlfu_pkg::LINE_CAPACITY_DEF,
  parameter int IMAGE_BYTES   = tlfu_pkg::IMAGE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tlfu_byte_if.sink     rx,
  tlfu_res_if.source    res,
  tlfu_cfg_if.sink      cfg
);

  localparam int HW_COUNT = (IMAGE_BYTES + 1) / 2;
  localparam int LA = $clog2(LINE_CAPACITY);
  localparam int LW = $clog2(LINE_CAPACITY + 1);
  localparam int IW = LW + 1;
  localparam int IA = $clog2(HW_COUNT);
  localparam int BW = $clog2(IMAGE_BYTES + 1);

  tlfu_pkg::state_t state, state_next;

  // Registers of the sequencer.
  logic [LW-1:0]  len, len_next;
  logic [LW-1:0]  ptr, ptr_next;
  logic [39:0]    hdr, hdr_next;
  logic [31:0]    acc_a, acc_a_next;
  logic [31:0]    acc_b, acc_b_next;
  logic [LW-1:0]  cnt, cnt_next;
  logic [IW-1:0]  idx, idx_next;
  logic [1:0]     nc, nc_next;
  logic [15:0]    hw, hw_next;
  logic [IA-1:0]  iaddr, iaddr_next;
  logic [IA-1:0]  ccnt, ccnt_next;
  logic [1:0]     k, k_next;
  logic [63:0]    bw, bw_next;
  logic [BW-1:0]  b, b_next;
  logic [31:0]    crc, crc_next;
  tlfu_pkg::status_t p_status, p_status_next;
  logic [31:0]    p_crc, p_crc_next;
  logic           p_start, p_start_next;

  logic           o_valid;
  logic [3:0]     o_status;
  logic [31:0]    o_crc;
  logic           o_start;

  logic [31:0]    app_base, stack_low, stack_high;

  // RAM ports.
  logic           lm_we;
  logic [7:0]     lm_rdata;
  logic           im_we;
  logic [IA-1:0]  im_waddr;
  logic [15:0]    im_wdata;
  logic [15:0]    im_rdata;

  tlfu_line_mem #(.DEPTH(LINE_CAPACITY)) u_line (
    .clk   (clk),
    .we    (lm_we),
    .waddr (len[LA-1:0]),
    .wdata (rx.rx_byte),
    .raddr (ptr_next[LA-1:0]),
    .rdata (lm_rdata)
  );

  tlfu_image_mem #(.DEPTH(HW_COUNT)) u_image (
    .clk   (clk),
    .we    (im_we),
    .waddr (im_waddr),
    .wdata (im_wdata),
    .raddr (iaddr_next),
    .rdata (im_rdata)
  );

  // Shared conditions. The line RAM always presents the character at ptr and the
  // image RAM the halfword at iaddr, because both are read at the next address.
  logic          rx_take, is_eol, out_free, at_end, is_space;
  logic [3:0]    cnib;
  logic [LW-1:0] count_c;
  logic          len_bad, range_bad, last_hw, hw_done;
  logic          old_erased, prog_ok, last_pair;
  logic [31:0]   lim;
  logic          crc_more;
  logic [32:0]   waddr_sum;
  logic [BW-1:0] b_inc;
  logic          sp_ok, pc_ok;
  logic          clr_last;

  assign rx.ready   = (state == tlfu_pkg::S_IDLE);
  assign rx_take    = rx.valid && rx.ready;
  assign is_eol     = (rx.rx_byte == tlfu_pkg::CH_CR) || (rx.rx_byte == tlfu_pkg::CH_LF);
  assign out_free   = !o_valid || res.ready;
  assign at_end     = (ptr >= len);
  assign is_space   = (lm_rdata == tlfu_pkg::CH_SPACE);
  assign cnib       = tlfu_pkg::nib(lm_rdata);
  assign count_c    = (len - ptr) >> 1;
  assign len_bad    = (count_c == '0) || (32'(count_c) > tlfu_pkg::MAX_DATA);
  assign range_bad  = ({1'b0, acc_a} + 33'(count_c)) > 33'(IMAGE_BYTES);
  assign last_hw    = (idx + IW'(1)) >= IW'(cnt);
  assign hw_done    = (nc == 2'd3) || (nc == 2'd1 && last_hw);
  assign waddr_sum  = {1'b0, acc_a} + 33'(idx);
  assign old_erased = (im_rdata == tlfu_pkg::ERASED_HW);
  assign prog_ok    = old_erased || (hw == 16'd0) || (im_rdata == hw);
  assign last_pair  = (idx + IW'(2)) >= IW'(cnt);
  assign lim        = (acc_a > 32'(IMAGE_BYTES)) ? 32'(IMAGE_BYTES) : acc_a;
  assign crc_more   = 32'(b) < lim;
  assign b_inc      = b + BW'(1);
  assign sp_ok      = (bw[31:0] >= stack_low) && (bw[31:0] <= stack_high);
  assign pc_ok      = (bw[63:32] >= app_base) &&
                      ({1'b0, bw[63:32]} <= ({1'b0, app_base} + 33'(IMAGE_BYTES)));
  assign clr_last   = (ccnt == IA'(HW_COUNT - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tlfu_pkg::S_CLEAR:  if (clr_last) state_next = tlfu_pkg::S_IDLE;
      tlfu_pkg::S_IDLE:   if (rx_take && is_eol && len != '0) state_next = tlfu_pkg::S_HDR;
      tlfu_pkg::S_HDR:    if (ptr == LW'(4)) state_next = tlfu_pkg::S_DECODE;
      tlfu_pkg::S_DECODE: begin
        if (len >= LW'(5) && hdr == tlfu_pkg::KW_HELLO) state_next = tlfu_pkg::S_DONE;
        else if (len >= LW'(5) && hdr == tlfu_pkg::KW_ERASE) state_next = tlfu_pkg::S_ERASE;
        else if (hdr[39:32] == tlfu_pkg::CH_W && len > LW'(4)) state_next = tlfu_pkg::S_W_OFF;
        else if (len >= LW'(4) && hdr[39:8] == tlfu_pkg::KW_CRC) state_next = tlfu_pkg::S_C_SIZE;
        else if (len >= LW'(4) && hdr[39:8] == tlfu_pkg::KW_BOOT) state_next = tlfu_pkg::S_B_RD;
        else state_next = tlfu_pkg::S_DONE;
      end
      tlfu_pkg::S_ERASE:  if (clr_last) state_next = tlfu_pkg::S_DONE;
      tlfu_pkg::S_W_OFF: begin
        if (at_end) state_next = tlfu_pkg::S_DONE;
        else if (is_space) state_next = tlfu_pkg::S_W_CHK;
      end
      tlfu_pkg::S_W_CHK: begin
        if (len_bad || range_bad) state_next = tlfu_pkg::S_DONE;
        else state_next = tlfu_pkg::S_W_DAT;
      end
      tlfu_pkg::S_W_DAT:  if (hw_done) state_next = tlfu_pkg::S_W_PRG;
      tlfu_pkg::S_W_PRG: begin
        if (!prog_ok || last_pair) state_next = tlfu_pkg::S_DONE;
        else state_next = tlfu_pkg::S_W_DAT;
      end
      tlfu_pkg::S_C_SIZE: begin
        if (at_end) state_next = tlfu_pkg::S_DONE;
        else if (is_space) state_next = tlfu_pkg::S_C_EXP;
      end
      tlfu_pkg::S_C_EXP:  if (at_end) state_next = tlfu_pkg::S_C_RUN;
      tlfu_pkg::S_C_RUN:  if (!crc_more) state_next = tlfu_pkg::S_DONE;
      tlfu_pkg::S_B_RD:   if (k == 2'd3) state_next = tlfu_pkg::S_B_CHK;
      tlfu_pkg::S_B_CHK:  state_next = tlfu_pkg::S_DONE;
      tlfu_pkg::S_DONE:   if (out_free) state_next = tlfu_pkg::S_IDLE;
      default:            state_next = tlfu_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM controls.
  always_comb begin
    len_next      = len;
    ptr_next      = ptr;
    hdr_next      = hdr;
    acc_a_next    = acc_a;
    acc_b_next    = acc_b;
    cnt_next      = cnt;
    idx_next      = idx;
    nc_next       = nc;
    hw_next       = hw;
    iaddr_next    = iaddr;
    ccnt_next     = ccnt;
    k_next        = k;
    bw_next       = bw;
    b_next        = b;
    crc_next      = crc;
    p_status_next = p_status;
    p_crc_next    = p_crc;
    p_start_next  = p_start;
    lm_we         = 1'b0;
    im_we         = 1'b0;
    im_waddr      = ccnt;
    im_wdata      = tlfu_pkg::ERASED_HW;
    case (state)
      tlfu_pkg::S_CLEAR: begin
        im_we     = 1'b1;
        ccnt_next = ccnt + IA'(1);
      end
      tlfu_pkg::S_IDLE: begin
        ptr_next = '0;
        if (rx_take && !is_eol && len < LW'(LINE_CAPACITY)) begin
          lm_we    = 1'b1;
          len_next = len + LW'(1);
        end
      end
      tlfu_pkg::S_HDR: begin
        hdr_next = {hdr[31:0], lm_rdata};
        ptr_next = ptr + LW'(1);
      end
      tlfu_pkg::S_DECODE: begin
        p_crc_next    = '0;
        p_start_next  = 1'b0;
        acc_a_next    = '0;
        acc_b_next    = '0;
        ccnt_next     = '0;
        iaddr_next    = '0;
        k_next        = '0;
        p_status_next = tlfu_pkg::ST_UNKNOWN;
        if (len >= LW'(5) && hdr == tlfu_pkg::KW_HELLO) begin
          p_status_next = tlfu_pkg::ST_BANNER;
        end else if (len >= LW'(5) && hdr == tlfu_pkg::KW_ERASE) begin
          p_status_next = tlfu_pkg::ST_OK;
        end else if (hdr[39:32] == tlfu_pkg::CH_W && len > LW'(4)) begin
          ptr_next = LW'(1);
        end else if (len >= LW'(4) && hdr[39:8] == tlfu_pkg::KW_CRC) begin
          ptr_next = LW'(4);
        end
      end
      tlfu_pkg::S_ERASE: begin
        im_we     = 1'b1;
        ccnt_next = ccnt + IA'(1);
      end
      tlfu_pkg::S_W_OFF: begin
        if (at_end) begin
          p_status_next = tlfu_pkg::ST_FORMAT;
        end else begin
          ptr_next = ptr + LW'(1);
          if (!is_space) acc_a_next = {acc_a[27:0], cnib};
        end
      end
      tlfu_pkg::S_W_CHK: begin
        cnt_next = count_c;
        idx_next = '0;
        nc_next  = '0;
        if (len_bad) p_status_next = tlfu_pkg::ST_LENGTH;
        else if (range_bad) p_status_next = tlfu_pkg::ST_RANGE;
      end
      tlfu_pkg::S_W_DAT: begin
        ptr_next = ptr + LW'(1);
        case (nc)
          2'd0:    hw_next[7:4]   = cnib;
          2'd1:    hw_next[3:0]   = cnib;
          2'd2:    hw_next[15:12] = cnib;
          2'd3:    hw_next[11:8]  = cnib;
          default: hw_next        = hw;
        endcase
        nc_next = nc + 2'd1;
        if (hw_done) begin
          if (nc == 2'd1) hw_next[15:8] = tlfu_pkg::PAD_BYTE;
          iaddr_next = waddr_sum[IA:1];
        end
      end
      tlfu_pkg::S_W_PRG: begin
        im_waddr = iaddr;
        im_wdata = hw;
        im_we    = old_erased || (hw == 16'd0);
        idx_next = idx + IW'(2);
        nc_next  = '0;
        if (!prog_ok) p_status_next = tlfu_pkg::ST_FLASH;
        else if (last_pair) p_status_next = tlfu_pkg::ST_OK;
      end
      tlfu_pkg::S_C_SIZE: begin
        if (at_end) begin
          p_status_next = tlfu_pkg::ST_FORMAT;
        end else begin
          ptr_next = ptr + LW'(1);
          if (!is_space) acc_a_next = {acc_a[27:0], cnib};
        end
      end
      tlfu_pkg::S_C_EXP: begin
        if (at_end) begin
          iaddr_next = '0;
          b_next     = '0;
          crc_next   = tlfu_pkg::CRC_INIT;
        end else begin
          ptr_next   = ptr + LW'(1);
          acc_b_next = {acc_b[27:0], cnib};
        end
      end
      tlfu_pkg::S_C_RUN: begin
        if (crc_more) begin
          crc_next   = tlfu_pkg::crc_byte(crc, b[0] ? im_rdata[15:8] : im_rdata[7:0]);
          b_next     = b_inc;
          iaddr_next = b_inc[IA:1];
        end else if (~crc == acc_b) begin
          p_status_next = tlfu_pkg::ST_OK;
        end else begin
          p_status_next = tlfu_pkg::ST_MISMATCH;
          p_crc_next    = ~crc;
        end
      end
      tlfu_pkg::S_B_RD: begin
        bw_next    = {im_rdata, bw[63:16]};
        k_next     = k + 2'd1;
        iaddr_next = IA'(k) + IA'(1);
      end
      tlfu_pkg::S_B_CHK: begin
        if (sp_ok && pc_ok) begin
          p_status_next = tlfu_pkg::ST_OK;
          p_start_next  = 1'b1;
        end else begin
          p_status_next = tlfu_pkg::ST_NO_APP;
        end
      end
      tlfu_pkg::S_DONE: begin
        if (out_free) len_next = '0;
      end
      default: begin
        ptr_next = ptr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlfu_pkg::S_CLEAR;
      len   <= '0;
      ccnt  <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
      ccnt  <= ccnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    hdr      <= hdr_next;
    acc_a    <= acc_a_next;
    acc_b    <= acc_b_next;
    cnt      <= cnt_next;
    idx      <= idx_next;
    nc       <= nc_next;
    hw       <= hw_next;
    iaddr    <= iaddr_next;
    k        <= k_next;
    bw       <= bw_next;
    b        <= b_next;
    crc      <= crc_next;
    p_status <= p_status_next;
    p_crc    <= p_crc_next;
    p_start  <= p_start_next;
  end

  // Output register: loaded when a command completes and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (state == tlfu_pkg::S_DONE && out_free) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tlfu_pkg::S_DONE && out_free) begin
      o_status <= p_status;
      o_crc    <= p_crc;
      o_start  <= p_start;
    end
  end

  assign res.valid     = o_valid;
  assign res.status    = o_status;
  assign res.crc_value = o_crc;
  assign res.start_app = o_start;

  // Configuration registers; an index beyond the list is ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      app_base   <= tlfu_pkg::APP_BASE_RST;
      stack_low  <= tlfu_pkg::STACK_LOW_RST;
      stack_high <= tlfu_pkg::STACK_HIGH_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        tlfu_pkg::CFG_APP_BASE:   app_base   <= cfg.data;
        tlfu_pkg::CFG_STACK_LOW:  stack_low  <= cfg.data;
        tlfu_pkg::CFG_STACK_HIGH: stack_high <= cfg.data;
        default:                  app_base   <= app_base;
      endcase
    end
  end

endmodule

FILE: sv/tlfu_line_mem.sv
`timescale 1ns / 1ps
// Line store: single-port-write, single-read synchronous RAM with a registered read.
// Stands alone; instanced by the top level. A same-address write is forwarded.
module tlfu_line_mem #(
  parameter int DEPTH = 579,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tlfu_image_mem.sv
`timescale 1ns / 1ps
// Image store of halfwords: synchronous RAM with a registered read.
// Stands alone; instanced by the top level. A same-address write is forwarded.
module tlfu_image_mem #(
  parameter int DEPTH = 51200,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tlfu_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the updater, attached to the top level by a bind statement.
// Depends on tlfu_pkg and on the top level's interface ports.
module tlfu_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [3:0]  status,
  input logic [31:0] crc_value,
  input logic        start_app
);

  // A result that is not taken holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(crc_value))
    else $error("result changed while stalled");

  // The byte channel is closed as the image sweep after reset begins.
  a_clear_blocks: assert property (@(posedge clk) rst |=> !rx_ready)
    else $error("byte channel open during the image sweep");

  // A start request only ever comes with an ok status.
  a_start_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && start_app |-> status == tlfu_pkg::ST_OK)
    else $error("start_app without ok status");

  // A CRC value is reported only with a mismatch.
  a_crc_only_mismatch: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != tlfu_pkg::ST_MISMATCH |-> crc_value == 32'd0)
    else $error("crc_value set on a non-mismatch result");

  // Status codes stay within the defined range.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status <= tlfu_pkg::ST_UNKNOWN)
    else $error("undefined status code");

endmodule

bind text_line_firmware_updater tlfu_checker u_tlfu_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .status    (res.status),
  .crc_value (res.crc_value),
  .start_app (res.start_app)
);
